@@ design/bsl_pkg.sv @@
package bsl_pkg;

  // Scan mode of the pending token
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_EQ     = 2'd3
  } mode_e;

  // Keyword tracker: prefix of "int" or "if" seen so far
  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_I    = 3'd1,
    KW_IN   = 3'd2,
    KW_INT  = 3'd3,
    KW_IF   = 3'd4
  } kw_e;

  // Token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    TK_IDENT   = 4'd0,
    TK_NUMBER  = 4'd1,
    TK_INT     = 4'd2,
    TK_IF      = 4'd3,
    TK_ASSIGN  = 4'd4,
    TK_PLUS    = 4'd5,
    TK_MINUS   = 4'd6,
    TK_EQUAL   = 4'd7,
    TK_LBRACE  = 4'd8,
    TK_RBRACE  = 4'd9,
    TK_SEMI    = 4'd10,
    TK_UNKNOWN = 4'd11,
    TK_EOF     = 4'd12
  } tok_e;

  // Result queue geometry
  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = 3;

  // Character codes
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChI      = 8'h69;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChF      = 8'h66;

  // One token on the result side
  typedef struct packed {
    tok_e        kind;
    logic [31:0] start;
    logic [7:0]  len;
    logic [7:0]  ch;
    logic        ovf;
    logic        last;
  } res_t;

  // Registered input item handed to the scanner
  typedef struct packed {
    logic       valid;
    logic [7:0] char_in;
    logic       eoi;
  } step_t;

  // Tokens produced by one step, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ design/bsl_if.sv @@
// Source byte channel
interface bsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// Token channel
interface bsl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] start_offset;
  logic [7:0]  token_length;
  logic [7:0]  single_char;
  logic        length_overflow;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output single_char,
                  output length_overflow, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input single_char,
                  input length_overflow, input last_of_run, output ready);
endinterface

@@ design/bsl_scan.sv @@
module bsl_scan #(
  parameter int unsigned MaxLexeme = 128,
  parameter int unsigned CntW      = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsl_pkg::step_t  step_i,
  output bsl_pkg::push_t  push_o
);

  bsl_pkg::mode_e  mode_q, mode_d;
  bsl_pkg::kw_e    kw_q, kw_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     begin_q, begin_d;
  logic [31:0]     pos_q, pos_d;
  logic            ovf_q, ovf_d;

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bsl_pkg::MODE_IDLE;
      kw_q    <= bsl_pkg::KW_NONE;
      cnt_q   <= '0;
      begin_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      cnt_q   <= cnt_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  // Classify the byte, flush the pending token and start the next one
  always_comb begin
    logic [7:0]     c;
    logic           flush_v;
    logic           start_v;
    logic           alnum;
    bsl_pkg::res_t  flush_r;
    bsl_pkg::res_t  start_r;
    bsl_pkg::res_t  eof_r;

    c     = step_i.char_in;
    alnum = bsl_pkg::is_letter(c) || bsl_pkg::is_digit(c);

    // Pending token as it would be emitted now
    flush_r       = '0;
    flush_r.start = begin_q;
    flush_v       = 1'b1;
    unique case (mode_q)
      bsl_pkg::MODE_IDENT: begin
        flush_r.kind = (kw_q == bsl_pkg::KW_INT) ? bsl_pkg::TK_INT :
                       (kw_q == bsl_pkg::KW_IF)  ? bsl_pkg::TK_IF  : bsl_pkg::TK_IDENT;
        flush_r.len  = 8'(cnt_q);
        flush_r.ovf  = ovf_q;
      end
      bsl_pkg::MODE_NUMBER: begin
        flush_r.kind = bsl_pkg::TK_NUMBER;
        flush_r.len  = 8'(cnt_q);
        flush_r.ovf  = ovf_q;
      end
      bsl_pkg::MODE_EQ: begin
        flush_r.kind = bsl_pkg::TK_ASSIGN;
        flush_r.len  = 8'd1;
        flush_r.ch   = bsl_pkg::ChEq;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase

    // Single-character token started by this byte
    start_r       = '0;
    start_r.start = pos_q;
    start_r.len   = 8'd1;
    start_r.ch    = c;
    start_v       = !bsl_pkg::is_space(c) && !alnum && (c != bsl_pkg::ChEq);
    priority case (c)
      bsl_pkg::ChPlus:   start_r.kind = bsl_pkg::TK_PLUS;
      bsl_pkg::ChMinus:  start_r.kind = bsl_pkg::TK_MINUS;
      bsl_pkg::ChLbrace: start_r.kind = bsl_pkg::TK_LBRACE;
      bsl_pkg::ChRbrace: start_r.kind = bsl_pkg::TK_RBRACE;
      bsl_pkg::ChSemi:   start_r.kind = bsl_pkg::TK_SEMI;
      default:           start_r.kind = bsl_pkg::TK_UNKNOWN;
    endcase

    eof_r       = '0;
    eof_r.kind  = bsl_pkg::TK_EOF;
    eof_r.start = pos_q;

    mode_d  = mode_q;
    kw_d    = kw_q;
    cnt_d   = cnt_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    push_o  = '0;

    if (step_i.valid) begin
      if (step_i.eoi) begin
        // Flush, then end of file; position holds
        mode_d = bsl_pkg::MODE_IDLE;
        kw_d   = bsl_pkg::KW_NONE;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        if (flush_v) begin
          push_o.n  = 2'd2;
          push_o.r0 = flush_r;
          push_o.r1 = eof_r;
        end else begin
          push_o.n  = 2'd1;
          push_o.r0 = eof_r;
        end
      end else begin
        pos_d = pos_q + 32'd1;
        if ((mode_q == bsl_pkg::MODE_IDENT && alnum) ||
            (mode_q == bsl_pkg::MODE_NUMBER && bsl_pkg::is_digit(c))) begin
          // Extend the lexeme, saturating the count
          if (cnt_q < CntW'(MaxLexeme)) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (mode_q == bsl_pkg::MODE_IDENT) begin
            if (kw_q == bsl_pkg::KW_I && c == bsl_pkg::ChN) begin
              kw_d = bsl_pkg::KW_IN;
            end else if (kw_q == bsl_pkg::KW_I && c == bsl_pkg::ChF) begin
              kw_d = bsl_pkg::KW_IF;
            end else if (kw_q == bsl_pkg::KW_IN && c == bsl_pkg::ChT) begin
              kw_d = bsl_pkg::KW_INT;
            end else begin
              kw_d = bsl_pkg::KW_NONE;
            end
          end
        end else if (mode_q == bsl_pkg::MODE_EQ && c == bsl_pkg::ChEq) begin
          // Second equals sign closes an equality token
          push_o.n        = 2'd1;
          push_o.r0       = '0;
          push_o.r0.kind  = bsl_pkg::TK_EQUAL;
          push_o.r0.start = begin_q;
          push_o.r0.len   = 8'd2;
          mode_d = bsl_pkg::MODE_IDLE;
          kw_d   = bsl_pkg::KW_NONE;
          cnt_d  = '0;
          ovf_d  = 1'b0;
        end else begin
          // Close the pending token and scan the byte afresh
          mode_d = bsl_pkg::MODE_IDLE;
          kw_d   = bsl_pkg::KW_NONE;
          cnt_d  = '0;
          ovf_d  = 1'b0;
          if (alnum) begin
            mode_d  = bsl_pkg::is_letter(c) ? bsl_pkg::MODE_IDENT : bsl_pkg::MODE_NUMBER;
            begin_d = pos_q;
            cnt_d   = CntW'(1);
            kw_d    = (c == bsl_pkg::ChI) ? bsl_pkg::KW_I : bsl_pkg::KW_NONE;
          end else if (c == bsl_pkg::ChEq) begin
            mode_d  = bsl_pkg::MODE_EQ;
            begin_d = pos_q;
            cnt_d   = CntW'(1);
          end
          if (flush_v && start_v) begin
            push_o.n  = 2'd2;
            push_o.r0 = flush_r;
            push_o.r1 = start_r;
          end else if (flush_v) begin
            push_o.n  = 2'd1;
            push_o.r0 = flush_r;
          end else if (start_v) begin
            push_o.n  = 2'd1;
            push_o.r0 = start_r;
          end
        end
      end
    end

    // Mark the final token of this step
    if (push_o.n == 2'd2) begin
      push_o.r1.last = 1'b1;
    end else if (push_o.n == 2'd1) begin
      push_o.r0.last = 1'b1;
    end
  end

endmodule

@@ design/bsl_fifo.sv @@
module bsl_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bsl_pkg::push_t          push_i,
  input  logic                    pop_i,
  output bsl_pkg::res_t           head_o,
  output logic                    valid_o,
  output logic [bsl_pkg::QAw:0]   level_o
);

  bsl_pkg::res_t                mem_q [bsl_pkg::QDepth];
  logic [bsl_pkg::QAw-1:0]      wr_q, wr_d;
  logic [bsl_pkg::QAw-1:0]      rd_q, rd_d;
  logic [bsl_pkg::QAw:0]        cnt_q, cnt_d;
  logic                         pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;
  assign pop     = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q + bsl_pkg::QAw'(push_i.n);
    rd_d  = rd_q + bsl_pkg::QAw'(pop);
    cnt_d = cnt_q + (bsl_pkg::QAw + 1)'(push_i.n) - (bsl_pkg::QAw + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store up to two tokens per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + bsl_pkg::QAw'(1)] <= push_i.r1;
    end
  end

endmodule

@@ design/byte_stream_lexer_core.sv @@
// Byte stream lexer.
// in_i carries one source byte, or an end mark, per transaction; out_o
// carries tokens (kind, start offset, length, single byte, overflow flag,
// and a flag on the last token caused by one input transaction).
// A byte accepted at one clock edge is scanned in the input register stage
// and its tokens (zero, one or two) enter an eight-entry result queue at the
// next edge; the first of them is offered on out_o from then on. A byte is
// accepted in every cycle while the queue has room for the worst case of two
// tokens beyond what it holds and what the scan stage is about to add; the
// queue drains one token per cycle while out_o is ready.
// Sustained rate: one byte per cycle, bounded by the single token per cycle
// that out_o can deliver.
// Reset empties the queue and the scan stage, returns the scanner to idle and
// sets the byte position to zero. When out_o stalls, tokens wait in the queue
// and in_i drops ready once the queue is nearly full; nothing is lost.
// The end mark flushes a pending token, then gives an eof token.
module byte_stream_lexer_core #(
  parameter int unsigned MAX_LEXEME = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsl_in_if.sink     in_i,
  bsl_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(MAX_LEXEME + 1);

  bsl_pkg::step_t          step_q, step_d;
  bsl_pkg::push_t          push;
  bsl_pkg::res_t           head;
  logic [bsl_pkg::QAw:0]   level;
  logic                    in_fire;

  // Accept while the queue can take two more tokens after the scan stage
  assign in_i.ready = ({1'b0, level} + (bsl_pkg::QAw + 2)'(push.n))
                      <= (bsl_pkg::QAw + 2)'(bsl_pkg::QDepth - 2);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    step_d         = step_q;
    step_d.valid   = in_fire;
    if (in_fire) begin
      step_d.char_in = in_i.char_in;
      step_d.eoi     = in_i.end_of_input;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  bsl_scan #(
    .MaxLexeme (MAX_LEXEME),
    .CntW      (CntW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_q),
    .push_o (push)
  );

  bsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (out_o.valid),
    .level_o (level)
  );

  assign out_o.token_kind      = head.kind;
  assign out_o.start_offset    = head.start;
  assign out_o.token_length    = head.len;
  assign out_o.single_char     = head.ch;
  assign out_o.length_overflow = head.ovf;
  assign out_o.last_of_run     = head.last;

  // Queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, level} + (bsl_pkg::QAw + 2)'(push.n)) <= (bsl_pkg::QAw + 2)'(bsl_pkg::QDepth))
    else $error("result queue overflow");

  // An end mark always yields at least the eof token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q.valid && step_q.eoi) |-> (push.n != 2'd0))
    else $error("end mark produced no token");

  // Only the last token of a pair carries the run flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("run flag misplaced in token pair");

  // Idle scan stage produces nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_q.valid |-> (push.n == 2'd0))
    else $error("token produced without an input");

  // Backpressure only with tokens queued or in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (level != '0))
    else $error("input stalled with an empty queue");

endmodule

@@ dv/tb_byte_stream_lexer_core.sv @@
module tb_byte_stream_lexer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LexMax     = 128;
  localparam int unsigned ItemTarget = 1500;
  localparam int unsigned QuietTail  = 200;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0]    ch;
    logic          eoi;
    logic          typed;
    bsl_pkg::res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsl_in_if  in_bus ();
  bsl_out_if out_bus ();

  byte_stream_lexer_core #(
    .MAX_LEXEME(LexMax)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #1 clk_i = ~clk_i;

  // Scanner state as predicted from the accepted byte stream
  bsl_pkg::mode_e lex_mode  = bsl_pkg::MODE_IDLE;
  bsl_pkg::kw_e   lex_kw    = bsl_pkg::KW_NONE;
  int unsigned    lex_len   = 0;
  logic [31:0]    lex_begin = '0;
  logic [31:0]    lex_pos   = '0;
  logic           lex_ovf   = 1'b0;

  bsl_pkg::res_t step_toks  [$];
  bsl_pkg::res_t tokens_due [$];
  int unsigned   mismatches = 0;
  int unsigned   sent_items = 0;
  int unsigned   stall_left = 0;
  logic          gaps_on    = 1'b0;

  stim_row_t dir_rows [24];
  string     kw_words [10] = '{"int", "if", "in", "i", "intx", "iff", "inT", "If", "if2", "nt"};
  string     op_chars      = "+-{};==";

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void emit(input bsl_pkg::tok_e k, input logic [31:0] s,
                               input logic [7:0] l, input logic [7:0] ch, input logic o);
    bsl_pkg::res_t r;
    r.kind  = k;
    r.start = s;
    r.len   = l;
    r.ch    = ch;
    r.ovf   = o;
    r.last  = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic void drop_pending();
    lex_mode = bsl_pkg::MODE_IDLE;
    lex_len  = 0;
    lex_kw   = bsl_pkg::KW_NONE;
    lex_ovf  = 1'b0;
  endfunction

  // Emit whatever token is pending, then return to idle
  function automatic void close_pending();
    bsl_pkg::tok_e k;
    case (lex_mode)
      bsl_pkg::MODE_IDENT: begin
        k = bsl_pkg::TK_IDENT;
        if (lex_kw == bsl_pkg::KW_INT) k = bsl_pkg::TK_INT;
        else if (lex_kw == bsl_pkg::KW_IF) k = bsl_pkg::TK_IF;
        emit(k, lex_begin, lex_len[7:0], 8'h00, lex_ovf);
      end
      bsl_pkg::MODE_NUMBER:
        emit(bsl_pkg::TK_NUMBER, lex_begin, lex_len[7:0], 8'h00, lex_ovf);
      bsl_pkg::MODE_EQ:
        emit(bsl_pkg::TK_ASSIGN, lex_begin, 8'd1, bsl_pkg::ChEq, 1'b0);
      default: ;
    endcase
    drop_pending();
  endfunction

  // Saturate the length and advance the keyword tracker
  function automatic void grow_lexeme(input logic [7:0] c);
    if (lex_len < LexMax) lex_len++;
    else lex_ovf = 1'b1;
    if (lex_mode == bsl_pkg::MODE_IDENT) begin
      if (lex_kw == bsl_pkg::KW_I && c == bsl_pkg::ChN) lex_kw = bsl_pkg::KW_IN;
      else if (lex_kw == bsl_pkg::KW_I && c == bsl_pkg::ChF) lex_kw = bsl_pkg::KW_IF;
      else if (lex_kw == bsl_pkg::KW_IN && c == bsl_pkg::ChT) lex_kw = bsl_pkg::KW_INT;
      else lex_kw = bsl_pkg::KW_NONE;
    end
  endfunction

  // Scan a byte from idle: skip, open a lexeme, or emit a single-byte token
  function automatic void open_token(input logic [7:0] c, input logic [31:0] at);
    bsl_pkg::tok_e k;
    if (is_blank(c)) return;
    if (is_alpha(c) || is_num(c)) begin
      if (is_alpha(c)) lex_mode = bsl_pkg::MODE_IDENT;
      else lex_mode = bsl_pkg::MODE_NUMBER;
      lex_begin = at;
      lex_len   = 1;
      lex_ovf   = 1'b0;
      if (c == bsl_pkg::ChI) lex_kw = bsl_pkg::KW_I;
      else lex_kw = bsl_pkg::KW_NONE;
    end else if (c == bsl_pkg::ChEq) begin
      lex_mode  = bsl_pkg::MODE_EQ;
      lex_begin = at;
      lex_len   = 1;
    end else begin
      case (c)
        bsl_pkg::ChPlus:   k = bsl_pkg::TK_PLUS;
        bsl_pkg::ChMinus:  k = bsl_pkg::TK_MINUS;
        bsl_pkg::ChLbrace: k = bsl_pkg::TK_LBRACE;
        bsl_pkg::ChRbrace: k = bsl_pkg::TK_RBRACE;
        bsl_pkg::ChSemi:   k = bsl_pkg::TK_SEMI;
        default:           k = bsl_pkg::TK_UNKNOWN;
      endcase
      emit(k, at, 8'd1, c, 1'b0);
    end
  endfunction

  // Work out the tokens one accepted transaction causes and queue them
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    logic [31:0] here;
    here = lex_pos;
    step_toks.delete();
    if (eoi) begin
      close_pending();
      emit(bsl_pkg::TK_EOF, lex_pos, 8'd0, 8'h00, 1'b0);
    end else begin
      case (lex_mode)
        bsl_pkg::MODE_IDENT, bsl_pkg::MODE_NUMBER: begin
          if (is_num(c) || (lex_mode == bsl_pkg::MODE_IDENT && is_alpha(c))) begin
            grow_lexeme(c);
          end else begin
            close_pending();
            open_token(c, here);
          end
        end
        bsl_pkg::MODE_EQ: begin
          if (c == bsl_pkg::ChEq) begin
            emit(bsl_pkg::TK_EQUAL, lex_begin, 8'd2, 8'h00, 1'b0);
            drop_pending();
          end else begin
            close_pending();
            open_token(c, here);
          end
        end
        default: open_token(c, here);
      endcase
      lex_pos = here + 32'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Hold the transaction until accepted, with an optional idle burst first
  task automatic send_item(input logic [7:0] c, input logic eoi);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.char_in      <= c;
    in_bus.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_tokens(c, eoi);
    sent_items++;
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned k;
    k = $urandom_range(0, 51);
    if (k < 26) return 8'h61 + k[7:0];
    return 8'h41 + k[7:0] - 8'd26;
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned k;
    k = $urandom_range(0, 61);
    if (k < 52) return rand_letter();
    return 8'h30 + k[7:0] - 8'd52;
  endfunction

  // Send one well-formed token, a piece of noise or an end mark
  task automatic send_chunk();
    int unsigned pick;
    int unsigned n;
    string       word;
    logic        as_num;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 12);
      send_item(rand_letter(), 1'b0);
      repeat (n - 1) send_item(rand_alnum(), 1'b0);
    end else if (pick < 37) begin
      word = kw_words[$urandom_range(0, 9)];
      for (int i = 0; i < word.len(); i++) send_item(word[i], 1'b0);
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 10)) send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 52) begin
      // Run past the length limit now and then
      as_num = $urandom_range(0, 1);
      n = $urandom_range(LexMax - 3, LexMax + 5);
      repeat (n) begin
        if (as_num) send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        else send_item(rand_alnum(), 1'b0);
      end
    end else if (pick < 72) begin
      send_item(op_chars[$urandom_range(0, 6)], 1'b0);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(0, 5);
        if (n == 5) send_item(8'h20, 1'b0);
        else send_item(8'h09 + n[7:0], 1'b0);
      end
    end else if (pick < 95) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Drive ready with random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare each token transaction with the oldest prediction
  always @(posedge clk_i) begin
    bsl_pkg::res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("token with nothing pending, kind", 32'(out_bus.token_kind), 32'd0);
      end else begin
        want = tokens_due.pop_front();
        if (out_bus.token_kind !== want.kind)
          report_mismatch("token_kind", 32'(out_bus.token_kind), 32'(want.kind));
        if (out_bus.start_offset !== want.start)
          report_mismatch("start_offset", out_bus.start_offset, want.start);
        if (out_bus.token_length !== want.len)
          report_mismatch("token_length", 32'(out_bus.token_length), 32'(want.len));
        if (out_bus.single_char !== want.ch)
          report_mismatch("single_char", 32'(out_bus.single_char), 32'(want.ch));
        if (out_bus.length_overflow !== want.ovf)
          report_mismatch("length_overflow", 32'(out_bus.length_overflow), 32'(want.ovf));
        if (out_bus.last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(out_bus.last_of_run), 32'(want.last));
      end
    end
  end

  // Bound the run
  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.char_in      = 8'h00;
    in_bus.end_of_input = 1'b0;
    out_bus.ready       = 1'b0;
    rst_ni              = 1'b0;

    dir_rows = '{
      // End mark straight after reset, then single-byte tokens at the byte extremes
      '{8'h00, 1'b1, 1'b1, '{bsl_pkg::TK_EOF, 32'd0, 8'd0, 8'h00, 1'b0, 1'b1}},
      '{bsl_pkg::ChPlus, 1'b0, 1'b1,
        '{bsl_pkg::TK_PLUS, 32'd0, 8'd1, bsl_pkg::ChPlus, 1'b0, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{bsl_pkg::TK_UNKNOWN, 32'd1, 8'd1, 8'hFF, 1'b0, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{bsl_pkg::TK_UNKNOWN, 32'd2, 8'd1, 8'h00, 1'b0, 1'b1}},
      '{bsl_pkg::ChMinus,  1'b0, 1'b0, '0},
      '{bsl_pkg::ChLbrace, 1'b0, 1'b0, '0},
      '{bsl_pkg::ChRbrace, 1'b0, 1'b0, '0},
      '{bsl_pkg::ChSemi,   1'b0, 1'b0, '0},
      '{8'h20,             1'b0, 1'b0, '0},
      '{8'h0D,             1'b0, 1'b0, '0},
      // Keyword int closed by whitespace
      '{bsl_pkg::ChI, 1'b0, 1'b0, '0},
      '{bsl_pkg::ChN, 1'b0, 1'b0, '0},
      '{bsl_pkg::ChT, 1'b0, 1'b0, '0},
      '{8'h09,        1'b0, 1'b0, '0},
      // Keyword if closed by '=', then '==' as equal
      '{bsl_pkg::ChI,  1'b0, 1'b0, '0},
      '{bsl_pkg::ChF,  1'b0, 1'b0, '0},
      '{bsl_pkg::ChEq, 1'b0, 1'b0, '0},
      '{bsl_pkg::ChEq, 1'b0, 1'b0, '0},
      // Lone '=' ended by a digit, number ended by a letter
      '{bsl_pkg::ChEq, 1'b0, 1'b0, '0},
      '{"9",           1'b0, 1'b0, '0},
      '{"0",           1'b0, 1'b0, '0},
      '{"x",           1'b0, 1'b0, '0},
      // Trailing '=' flushed as assign by the end mark
      '{bsl_pkg::ChEq, 1'b0, 1'b0, '0},
      '{"A",           1'b1, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    gaps_on = 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].ch, dir_rows[i].eoi);
      if (dir_rows[i].typed) tokens_due[tokens_due.size() - 1] = dir_rows[i].want;
    end

    // Hold off until every token is out
    in_bus.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);

    // Random stream, with a quiet tail at full rate
    while (sent_items < ItemTarget) begin
      gaps_on = (sent_items < ItemTarget - QuietTail) && ($urandom_range(0, 3) != 0);
      send_chunk();
    end
    send_item(8'h00, 1'b1);
    in_bus.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
